/* sv/rrsp_pkg.sv */
// rrsp_pkg: shared types and constants for the resp reply stream parser
`timescale 1ns / 1ps

package rrsp_pkg;

   localparam int LENGTH_BITS = 31;
   localparam int LEN_W       = 31;
   localparam int ACC_W       = LEN_W + 4;

   localparam logic [ACC_W-1:0] LEN_LIMIT = (LENGTH_BITS >= 31) ?
      ACC_W'(35'h7FFF_FFFF) : ((ACC_W'(1) << LENGTH_BITS) - ACC_W'(1));

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [3:0] {
      PH_TYPE      = 4'd0,
      PH_LINE      = 4'd1,
      PH_LINE_LF   = 4'd2,
      PH_LEN_START = 4'd3,
      PH_LEN_MINUS = 4'd4,
      PH_LEN_DIGIT = 4'd5,
      PH_LEN_LF    = 4'd6,
      PH_BULK_DATA = 4'd7,
      PH_BULK_CR   = 4'd8,
      PH_BULK_LF   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      EV_HEADER  = 2'd0,
      EV_PAYLOAD = 2'd1,
      EV_END     = 2'd2,
      EV_ERROR   = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      T_SIMPLE  = 3'd0,
      T_ERROR   = 3'd1,
      T_INTEGER = 3'd2,
      T_BULK    = 3'd3,
      T_ARRAY   = 3'd4,
      T_UNKNOWN = 3'd5
   } elem_kind_type;

   typedef struct packed {
      phase_type        phase;
      elem_kind_type    cur_type;
      logic [LEN_W-1:0] accum;
      logic [LEN_W-1:0] left;
      logic             neg;
   } parse_state_type;

   typedef struct packed {
      logic             valid;
      event_type        ev;
      elem_kind_type    kind;
      logic [LEN_W-1:0] len;
      logic             nul;
      logic [7:0]       data;
   } parse_result_type;

endpackage

/* sv/rrsp_step.sv */
// rrsp_step: next parser state and result word for one received byte
`timescale 1ns / 1ps

module rrsp_step (
   input  rrsp_pkg::parse_state_type  state_cur,
   input  logic [7:0]                 rx_byte,
   output rrsp_pkg::parse_state_type  state_nxt,
   output rrsp_pkg::parse_result_type result
);

   logic                         is_digit;
   logic [rrsp_pkg::ACC_W-1:0]   acc_wide;
   logic [rrsp_pkg::ACC_W-1:0]   acc_val;
   logic [rrsp_pkg::LEN_W-1:0]   left_dec;

   assign is_digit = (rx_byte >= rrsp_pkg::CH_ZERO) && (rx_byte <= rrsp_pkg::CH_NINE);

   // accum * 10 + digit
   always_comb begin
      acc_wide = rrsp_pkg::ACC_W'(state_cur.accum);
      if (state_cur.phase == rrsp_pkg::PH_LEN_DIGIT) begin
         acc_val = (acc_wide << 3) + (acc_wide << 1);
      end else begin
         acc_val = '0;
      end
      acc_val = acc_val + rrsp_pkg::ACC_W'(rx_byte[3:0]);
   end

   assign left_dec = (state_cur.left != '0) ? state_cur.left - 1'b1 : state_cur.left;

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      case (state_cur.phase)
         rrsp_pkg::PH_LINE: begin
            if (rx_byte == rrsp_pkg::CH_CR) begin
               state_nxt.phase = rrsp_pkg::PH_LINE_LF;
            end else begin
               result.valid = 1'b1;
               result.ev    = rrsp_pkg::EV_PAYLOAD;
               result.kind  = state_cur.cur_type;
               result.data  = rx_byte;
            end
         end
         rrsp_pkg::PH_LINE_LF, rrsp_pkg::PH_BULK_LF: begin
            state_nxt.phase = rrsp_pkg::PH_TYPE;
            state_nxt.accum = '0;
            state_nxt.left  = '0;
            state_nxt.neg   = 1'b0;
            result.valid    = 1'b1;
            result.kind     = state_cur.cur_type;
            if (rx_byte != rrsp_pkg::CH_LF) begin
               result.ev   = rrsp_pkg::EV_ERROR;
               result.data = rx_byte;
            end else begin
               result.ev = rrsp_pkg::EV_END;
            end
         end
         rrsp_pkg::PH_LEN_START, rrsp_pkg::PH_LEN_MINUS, rrsp_pkg::PH_LEN_DIGIT: begin
            if (state_cur.phase == rrsp_pkg::PH_LEN_START && rx_byte == rrsp_pkg::CH_MINUS)
            begin
               state_nxt.neg   = 1'b1;
               state_nxt.phase = rrsp_pkg::PH_LEN_MINUS;
            end else if (is_digit && acc_val <= rrsp_pkg::LEN_LIMIT) begin
               state_nxt.accum = acc_val[rrsp_pkg::LEN_W-1:0];
               state_nxt.phase = rrsp_pkg::PH_LEN_DIGIT;
            end else if (!is_digit && rx_byte == rrsp_pkg::CH_CR &&
                         state_cur.phase == rrsp_pkg::PH_LEN_DIGIT) begin
               state_nxt.phase = rrsp_pkg::PH_LEN_LF;
            end else begin
               state_nxt.phase = rrsp_pkg::PH_TYPE;
               state_nxt.accum = '0;
               state_nxt.left  = '0;
               state_nxt.neg   = 1'b0;
               result.valid    = 1'b1;
               result.ev       = rrsp_pkg::EV_ERROR;
               result.kind     = state_cur.cur_type;
               result.data     = rx_byte;
            end
         end
         rrsp_pkg::PH_LEN_LF: begin
            result.valid = 1'b1;
            result.kind  = state_cur.cur_type;
            if (rx_byte != rrsp_pkg::CH_LF) begin
               state_nxt.phase = rrsp_pkg::PH_TYPE;
               state_nxt.accum = '0;
               state_nxt.left  = '0;
               state_nxt.neg   = 1'b0;
               result.ev       = rrsp_pkg::EV_ERROR;
               result.data     = rx_byte;
            end else if (state_cur.neg) begin
               state_nxt.phase = rrsp_pkg::PH_TYPE;
               state_nxt.accum = '0;
               state_nxt.left  = '0;
               state_nxt.neg   = 1'b0;
               result.ev       = rrsp_pkg::EV_HEADER;
               result.nul      = 1'b1;
            end else begin
               result.ev  = rrsp_pkg::EV_HEADER;
               result.len = state_cur.accum;
               if (state_cur.cur_type == rrsp_pkg::T_BULK) begin
                  state_nxt.left  = state_cur.accum;
                  state_nxt.phase = (state_cur.accum != '0) ? rrsp_pkg::PH_BULK_DATA
                                                            : rrsp_pkg::PH_BULK_CR;
               end else begin
                  state_nxt.phase = rrsp_pkg::PH_TYPE;
                  state_nxt.accum = '0;
                  state_nxt.left  = '0;
                  state_nxt.neg   = 1'b0;
               end
            end
         end
         rrsp_pkg::PH_BULK_DATA: begin
            state_nxt.left = left_dec;
            if (left_dec == '0) begin
               state_nxt.phase = rrsp_pkg::PH_BULK_CR;
            end
            result.valid = 1'b1;
            result.ev    = rrsp_pkg::EV_PAYLOAD;
            result.kind  = state_cur.cur_type;
            result.data  = rx_byte;
         end
         rrsp_pkg::PH_BULK_CR: begin
            if (rx_byte != rrsp_pkg::CH_CR) begin
               state_nxt.phase = rrsp_pkg::PH_TYPE;
               state_nxt.accum = '0;
               state_nxt.left  = '0;
               state_nxt.neg   = 1'b0;
               result.valid    = 1'b1;
               result.ev       = rrsp_pkg::EV_ERROR;
               result.kind     = state_cur.cur_type;
               result.data     = rx_byte;
            end else begin
               state_nxt.phase = rrsp_pkg::PH_BULK_LF;
            end
         end
         default: begin
            // expecting a type byte
            state_nxt.phase = rrsp_pkg::PH_TYPE;
            state_nxt.accum = '0;
            state_nxt.left  = '0;
            state_nxt.neg   = 1'b0;
            result.valid    = 1'b1;
            result.ev       = rrsp_pkg::EV_HEADER;
            case (rx_byte)
               rrsp_pkg::CH_PLUS: begin
                  state_nxt.cur_type = rrsp_pkg::T_SIMPLE;
                  state_nxt.phase    = rrsp_pkg::PH_LINE;
                  result.kind        = rrsp_pkg::T_SIMPLE;
               end
               rrsp_pkg::CH_MINUS: begin
                  state_nxt.cur_type = rrsp_pkg::T_ERROR;
                  state_nxt.phase    = rrsp_pkg::PH_LINE;
                  result.kind        = rrsp_pkg::T_ERROR;
               end
               rrsp_pkg::CH_COLON: begin
                  state_nxt.cur_type = rrsp_pkg::T_INTEGER;
                  state_nxt.phase    = rrsp_pkg::PH_LINE;
                  result.kind        = rrsp_pkg::T_INTEGER;
               end
               rrsp_pkg::CH_DOLLAR: begin
                  state_nxt.cur_type = rrsp_pkg::T_BULK;
                  state_nxt.phase    = rrsp_pkg::PH_LEN_START;
                  result.valid       = 1'b0;
               end
               rrsp_pkg::CH_STAR: begin
                  state_nxt.cur_type = rrsp_pkg::T_ARRAY;
                  state_nxt.phase    = rrsp_pkg::PH_LEN_START;
                  result.valid       = 1'b0;
               end
               default: begin
                  result.ev   = rrsp_pkg::EV_ERROR;
                  result.kind = rrsp_pkg::T_UNKNOWN;
                  result.data = rx_byte;
               end
            endcase
         end
      endcase
   end

endmodule

/* sv/resp_reply_stream_parser_core.sv */
// resp_reply_stream_parser_core: top level of the resp2 reply byte stream parser
//
// req channel: one received reply byte per word (req_rx_byte), valid/ready.
// rsp channel: one event word (header, payload byte, element end or framing
// error) with type, length, null flag and data byte, valid/ready.
// a byte that produces no event (type byte of bulk/array, length digits, cr)
// is consumed silently.
// a byte is held in an input register, then the parser logic updates the
// parse state and loads the event into the output register.
// throughput: one byte per cycle while the output register is empty or being taken.
// a full output register stalls the parser stage only when it is not being
// taken; req_ready drops when both the input and output registers are held.
// reset (synchronous, active high) returns the parser to waiting for a type
// byte and empties both registers.
`timescale 1ns / 1ps

module resp_reply_stream_parser_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_event_res,
   output logic [2:0]                  rsp_elem_type,
   output logic [rrsp_pkg::LEN_W-1:0]  rsp_length,
   output logic                        rsp_is_null,
   output logic [7:0]                  rsp_data_byte
);

   logic                        in_valid_ff;
   logic [7:0]                  in_byte_ff;
   logic                        advance;
   rrsp_pkg::parse_state_type   state_ff;
   rrsp_pkg::parse_state_type   state_in;
   rrsp_pkg::parse_result_type  step_res;
   logic                        out_valid_ff;
   rrsp_pkg::parse_result_type  out_ff;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   rrsp_step u_step (
      .state_cur (state_ff),
      .rx_byte   (in_byte_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase    <= rrsp_pkg::PH_TYPE;
         state_ff.cur_type <= rrsp_pkg::T_SIMPLE;
         state_ff.accum    <= '0;
         state_ff.left     <= '0;
         state_ff.neg      <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && step_res.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && step_res.valid) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = out_ff.ev;
   assign rsp_elem_type = out_ff.kind;
   assign rsp_length    = out_ff.len;
   assign rsp_is_null   = out_ff.nul;
   assign rsp_data_byte = out_ff.data;

endmodule

/* test/tb_resp_reply_stream_parser_core.sv */
// tb_resp_reply_stream_parser_core: self-checking testbench for the resp2 reply byte stream parser
`timescale 1ns / 1ps

module tb_resp_reply_stream_parser_core;

   localparam int LEN_W = rrsp_pkg::LEN_W;
   localparam int unsigned RANDOM_BYTES = 1920;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned HOLD_AFTER   = 400;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PRINT_LIMIT  = 40;
   localparam longint unsigned LEN_MAX = (rrsp_pkg::LENGTH_BITS >= 31) ? 64'h7FFF_FFFF
      : ((64'd1 << rrsp_pkg::LENGTH_BITS) - 64'd1);

   typedef struct packed {
      rrsp_pkg::event_type     ev;
      rrsp_pkg::elem_kind_type kind;
      logic [LEN_W-1:0]        len;
      logic                    nul;
      logic [7:0]              data;
   } parser_event_type;

   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_SILENT,
      ROW_EVENT
   } row_kind_type;

   typedef struct packed {
      logic [7:0]       rx;
      row_kind_type     kind;
      parser_event_type ev;
   } directed_row_type;

   localparam parser_event_type NO_EVENT = '0;
   localparam logic [7:0] TYPE_BYTES [5] = '{rrsp_pkg::CH_PLUS, rrsp_pkg::CH_MINUS,
      rrsp_pkg::CH_COLON, rrsp_pkg::CH_DOLLAR, rrsp_pkg::CH_STAR};

   localparam int DIRECTED_ROWS = 31;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'hFF, ROW_EVENT,
        '{rrsp_pkg::EV_ERROR, rrsp_pkg::T_UNKNOWN, '0, 1'b0, 8'hFF}},
      '{rrsp_pkg::CH_DOLLAR, ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_MINUS,  ROW_SILENT, NO_EVENT},
      '{8'h31,               ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_CR,     ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_LF, ROW_EVENT,
        '{rrsp_pkg::EV_HEADER, rrsp_pkg::T_BULK, '0, 1'b1, 8'h00}},
      '{rrsp_pkg::CH_STAR,   ROW_SILENT, NO_EVENT},
      '{8'h33,               ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_CR,     ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_LF, ROW_EVENT,
        '{rrsp_pkg::EV_HEADER, rrsp_pkg::T_ARRAY, LEN_W'(3), 1'b0, 8'h00}},
      '{rrsp_pkg::CH_DOLLAR, ROW_SILENT, NO_EVENT},
      '{8'h31,               ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_CR,     ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_LF, ROW_EVENT,
        '{rrsp_pkg::EV_HEADER, rrsp_pkg::T_BULK, LEN_W'(1), 1'b0, 8'h00}},
      '{8'h00, ROW_EVENT,
        '{rrsp_pkg::EV_PAYLOAD, rrsp_pkg::T_BULK, '0, 1'b0, 8'h00}},
      '{8'h00, ROW_EVENT,
        '{rrsp_pkg::EV_ERROR, rrsp_pkg::T_BULK, '0, 1'b0, 8'h00}},
      '{rrsp_pkg::CH_PLUS, ROW_EVENT,
        '{rrsp_pkg::EV_HEADER, rrsp_pkg::T_SIMPLE, '0, 1'b0, 8'h00}},
      '{8'hFF,               ROW_MODEL,  NO_EVENT},
      '{rrsp_pkg::CH_CR,     ROW_SILENT, NO_EVENT},
      '{8'h00, ROW_EVENT,
        '{rrsp_pkg::EV_ERROR, rrsp_pkg::T_SIMPLE, '0, 1'b0, 8'h00}},
      '{rrsp_pkg::CH_DOLLAR, ROW_SILENT, NO_EVENT},
      '{8'h78, ROW_EVENT,
        '{rrsp_pkg::EV_ERROR, rrsp_pkg::T_BULK, '0, 1'b0, 8'h78}},
      '{rrsp_pkg::CH_COLON, ROW_EVENT,
        '{rrsp_pkg::EV_HEADER, rrsp_pkg::T_INTEGER, '0, 1'b0, 8'h00}},
      '{8'h34,               ROW_MODEL,  NO_EVENT},
      '{rrsp_pkg::CH_CR,     ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_LF,     ROW_MODEL,  NO_EVENT},
      '{rrsp_pkg::CH_MINUS, ROW_EVENT,
        '{rrsp_pkg::EV_HEADER, rrsp_pkg::T_ERROR, '0, 1'b0, 8'h00}},
      '{rrsp_pkg::CH_CR,     ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_LF, ROW_EVENT,
        '{rrsp_pkg::EV_END, rrsp_pkg::T_ERROR, '0, 1'b0, 8'h00}},
      '{rrsp_pkg::CH_DOLLAR, ROW_SILENT, NO_EVENT},
      '{rrsp_pkg::CH_CR, ROW_EVENT,
        '{rrsp_pkg::EV_ERROR, rrsp_pkg::T_BULK, '0, 1'b0, rrsp_pkg::CH_CR}}
   };

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   logic [1:0]       rsp_event_res;
   logic [2:0]       rsp_elem_type;
   logic [LEN_W-1:0] rsp_length;
   logic             rsp_is_null;
   logic [7:0]       rsp_data_byte;

   parser_event_type expected_events [$];
   logic [7:0]       elem_bytes [$];
   int unsigned      mismatch_count = 0;
   int unsigned      results_seen   = 0;
   int unsigned      idle_cycles    = 0;
   int unsigned      burst_left     = 0;

   rrsp_pkg::phase_type     model_phase = rrsp_pkg::PH_TYPE;
   rrsp_pkg::elem_kind_type model_kind  = rrsp_pkg::T_SIMPLE;
   logic [LEN_W-1:0]        model_accum = '0;
   logic [LEN_W-1:0]        model_left  = '0;
   logic                    model_neg   = 1'b0;

   resp_reply_stream_parser_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .rsp_elem_type (rsp_elem_type),
      .rsp_length    (rsp_length),
      .rsp_is_null   (rsp_is_null),
      .rsp_data_byte (rsp_data_byte)
   );

   always #1 clock = ~clock;

   task automatic clear_length_state();
      model_accum = '0;
      model_left  = '0;
      model_neg   = 1'b0;
   endtask

   task automatic advance_parser(input logic [7:0] rx, output bit produced,
                                 output parser_event_type ev);
      longint unsigned         v;
      bit                      fail;
      rrsp_pkg::elem_kind_type fail_kind;
      produced  = 1'b0;
      ev        = NO_EVENT;
      fail      = 1'b0;
      fail_kind = model_kind;
      case (model_phase)
         rrsp_pkg::PH_LINE: begin
            if (rx == rrsp_pkg::CH_CR) begin
               model_phase = rrsp_pkg::PH_LINE_LF;
            end else begin
               produced = 1'b1;
               ev = '{rrsp_pkg::EV_PAYLOAD, model_kind, '0, 1'b0, rx};
            end
         end
         rrsp_pkg::PH_LINE_LF, rrsp_pkg::PH_BULK_LF: begin
            if (rx != rrsp_pkg::CH_LF) begin
               fail = 1'b1;
            end else begin
               model_phase = rrsp_pkg::PH_TYPE;
               clear_length_state();
               produced = 1'b1;
               ev = '{rrsp_pkg::EV_END, model_kind, '0, 1'b0, 8'h00};
            end
         end
         rrsp_pkg::PH_LEN_START, rrsp_pkg::PH_LEN_MINUS, rrsp_pkg::PH_LEN_DIGIT: begin
            if (model_phase == rrsp_pkg::PH_LEN_START && rx == rrsp_pkg::CH_MINUS) begin
               model_neg   = 1'b1;
               model_phase = rrsp_pkg::PH_LEN_MINUS;
            end else if (rx >= rrsp_pkg::CH_ZERO && rx <= rrsp_pkg::CH_NINE) begin
               v = (model_phase == rrsp_pkg::PH_LEN_DIGIT) ?
                   64'(model_accum) * 64'd10 : 64'd0;
               v += 64'(rx - rrsp_pkg::CH_ZERO);
               if (v > LEN_MAX) begin
                  fail = 1'b1;
               end else begin
                  model_accum = v[LEN_W-1:0];
                  model_phase = rrsp_pkg::PH_LEN_DIGIT;
               end
            end else if (rx == rrsp_pkg::CH_CR && model_phase == rrsp_pkg::PH_LEN_DIGIT) begin
               model_phase = rrsp_pkg::PH_LEN_LF;
            end else begin
               fail = 1'b1;
            end
         end
         rrsp_pkg::PH_LEN_LF: begin
            if (rx != rrsp_pkg::CH_LF) begin
               fail = 1'b1;
            end else if (model_neg) begin
               model_phase = rrsp_pkg::PH_TYPE;
               clear_length_state();
               produced = 1'b1;
               ev = '{rrsp_pkg::EV_HEADER, model_kind, '0, 1'b1, 8'h00};
            end else begin
               produced = 1'b1;
               ev = '{rrsp_pkg::EV_HEADER, model_kind, model_accum, 1'b0, 8'h00};
               if (model_kind == rrsp_pkg::T_BULK) begin
                  model_left  = model_accum;
                  model_phase = (model_accum != '0) ? rrsp_pkg::PH_BULK_DATA
                                                    : rrsp_pkg::PH_BULK_CR;
               end else begin
                  model_phase = rrsp_pkg::PH_TYPE;
                  clear_length_state();
               end
            end
         end
         rrsp_pkg::PH_BULK_DATA: begin
            if (model_left != '0) model_left = model_left - 1'b1;
            if (model_left == '0) model_phase = rrsp_pkg::PH_BULK_CR;
            produced = 1'b1;
            ev = '{rrsp_pkg::EV_PAYLOAD, model_kind, '0, 1'b0, rx};
         end
         rrsp_pkg::PH_BULK_CR: begin
            if (rx != rrsp_pkg::CH_CR) fail = 1'b1;
            else model_phase = rrsp_pkg::PH_BULK_LF;
         end
         default: begin
            clear_length_state();
            model_phase = rrsp_pkg::PH_TYPE;
            case (rx)
               rrsp_pkg::CH_PLUS: begin
                  model_kind  = rrsp_pkg::T_SIMPLE;
                  model_phase = rrsp_pkg::PH_LINE;
               end
               rrsp_pkg::CH_MINUS: begin
                  model_kind  = rrsp_pkg::T_ERROR;
                  model_phase = rrsp_pkg::PH_LINE;
               end
               rrsp_pkg::CH_COLON: begin
                  model_kind  = rrsp_pkg::T_INTEGER;
                  model_phase = rrsp_pkg::PH_LINE;
               end
               rrsp_pkg::CH_DOLLAR: begin
                  model_kind  = rrsp_pkg::T_BULK;
                  model_phase = rrsp_pkg::PH_LEN_START;
               end
               rrsp_pkg::CH_STAR: begin
                  model_kind  = rrsp_pkg::T_ARRAY;
                  model_phase = rrsp_pkg::PH_LEN_START;
               end
               default: begin
                  fail      = 1'b1;
                  fail_kind = rrsp_pkg::T_UNKNOWN;
               end
            endcase
            if (model_phase == rrsp_pkg::PH_LINE) begin
               produced = 1'b1;
               ev = '{rrsp_pkg::EV_HEADER, model_kind, '0, 1'b0, 8'h00};
            end
         end
      endcase
      // framing error: drop the number state and wait for a new type byte
      if (fail) begin
         model_phase = rrsp_pkg::PH_TYPE;
         clear_length_state();
         produced = 1'b1;
         ev = '{rrsp_pkg::EV_ERROR, fail_kind, '0, 1'b0, rx};
      end
   endtask

   task automatic send_byte(input logic [7:0] rx);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic feed_byte(input logic [7:0] rx, input row_kind_type kind,
                            input parser_event_type typed);
      bit               produced;
      parser_event_type ev;
      send_byte(rx);
      advance_parser(rx, produced, ev);
      case (kind)
         ROW_MODEL:  if (produced) expected_events.push_back(ev);
         ROW_EVENT:  expected_events.push_back(typed);
         default:    ;
      endcase
   endtask

   task automatic append_decimal(input longint unsigned value);
      string digits;
      digits = $sformatf("%0d", value);
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 3)) elem_bytes.push_back(rrsp_pkg::CH_ZERO);
      end
      for (int i = 0; i < digits.len(); i++) elem_bytes.push_back(digits[i]);
   endtask

   // mostly the proper terminator, now and then a stray byte
   function automatic logic [7:0] term_byte(input logic [7:0] good);
      return ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : good;
   endfunction

   task automatic report_mismatch(input string field, input longint want_v,
                                  input longint got_v);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at %0t: %s expected %0h got %0h", $time, field, want_v, got_v);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      parser_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected word, event", -1, rsp_event_res);
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_res !== want.ev)
               report_mismatch("event", want.ev, rsp_event_res);
            if (rsp_elem_type !== want.kind)
               report_mismatch("elem_type", want.kind, rsp_elem_type);
            if (rsp_length !== want.len)
               report_mismatch("length", want.len, rsp_length);
            if (rsp_is_null !== want.nul)
               report_mismatch("is_null", want.nul, rsp_is_null);
            if (rsp_data_byte !== want.data)
               report_mismatch("data_byte", want.data, rsp_data_byte);
         end
      end
   end

   int unsigned hold_left   = 0;
   bit          hold_done   = 1'b0;
   int unsigned stall_mode  = 0;
   int unsigned mode_left   = 0;

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(8, 64);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      bit              pause_done;
      int unsigned     random_sent;
      int unsigned     pick;
      int unsigned     count;
      logic [7:0]      b;
      longint unsigned value;
      pause_done  = 1'b0;
      random_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         feed_byte(DIRECTED[i].rx, DIRECTED[i].kind, DIRECTED[i].ev);

      while (random_sent < RANDOM_BYTES) begin
         elem_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // simple, error or integer line
            elem_bytes.push_back(TYPE_BYTES[$urandom_range(0, 2)]);
            repeat ($urandom_range(0, 10)) begin
               b = 8'($urandom_range(0, 255));
               elem_bytes.push_back((b == rrsp_pkg::CH_CR) ? rrsp_pkg::CH_LF : b);
            end
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_CR));
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_LF));
         end else if (pick < 55) begin
            elem_bytes.push_back(rrsp_pkg::CH_DOLLAR);
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            append_decimal(count);
            elem_bytes.push_back(rrsp_pkg::CH_CR);
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_LF));
            repeat (count) elem_bytes.push_back(8'($urandom_range(0, 255)));
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_CR));
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_LF));
         end else if (pick < 70) begin
            elem_bytes.push_back(rrsp_pkg::CH_STAR);
            case ($urandom_range(0, 3))
               0:       value = $urandom_range(0, 5);
               1:       value = 64'($urandom) & LEN_MAX;
               2:       value = LEN_MAX;
               default: value = $urandom_range(0, 99999);
            endcase
            append_decimal(value);
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_CR));
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_LF));
         end else if (pick < 78) begin
            // null bulk or array
            elem_bytes.push_back(TYPE_BYTES[$urandom_range(3, 4)]);
            elem_bytes.push_back(rrsp_pkg::CH_MINUS);
            value = ($urandom_range(0, 3) == 0) ? (64'($urandom) & LEN_MAX)
                                                : 64'($urandom_range(0, 9));
            append_decimal(value);
            elem_bytes.push_back(rrsp_pkg::CH_CR);
            elem_bytes.push_back(term_byte(rrsp_pkg::CH_LF));
         end else if (pick < 86) begin
            // length past the limit, then the terminator after recovery
            elem_bytes.push_back(TYPE_BYTES[$urandom_range(3, 4)]);
            if ($urandom_range(0, 2) == 0) elem_bytes.push_back(rrsp_pkg::CH_MINUS);
            value = LEN_MAX + 64'd1 + (($urandom_range(0, 1) == 0) ?
                    64'($urandom_range(0, 999)) : 64'($urandom));
            append_decimal(value);
            elem_bytes.push_back(rrsp_pkg::CH_CR);
            elem_bytes.push_back(rrsp_pkg::CH_LF);
         end else if (pick < 94) begin
            elem_bytes.push_back(TYPE_BYTES[$urandom_range(0, 4)]);
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 5))
                  0:       b = rrsp_pkg::CH_CR;
                  1:       b = rrsp_pkg::CH_LF;
                  2:       b = rrsp_pkg::CH_MINUS;
                  3:       b = rrsp_pkg::CH_ZERO;
                  4:       b = rrsp_pkg::CH_NINE;
                  default: b = 8'($urandom_range(0, 255));
               endcase
               elem_bytes.push_back(b);
            end
         end else begin
            repeat ($urandom_range(1, 3)) elem_bytes.push_back(8'($urandom_range(0, 255)));
         end

         foreach (elem_bytes[i]) feed_byte(elem_bytes[i], ROW_MODEL, NO_EVENT);
         random_sent += elem_bytes.size();

         if (!pause_done && random_sent >= RANDOM_BYTES / 2) begin
            pause_done = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_events.size() != 0);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
